@@ design/ellipse_rasterizer_defines.svh @@
// Assertion macros shared by the ellipse rasterizer RTL.
// The including module must provide i_clk and the active-low reset i_rst_n.
`ifndef ELLIPSE_RASTERIZER_DEFINES_SVH
`define ELLIPSE_RASTERIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ellras_pkg.sv @@
// Types and codes for the ellipse rasterizer.
// Used by ellipse_rasterizer; depends on nothing else.
`default_nettype none

package ellras_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_SQX  = 14'b00000000000010,
        ST_SQY  = 14'b00000000000100,
        ST_T    = 14'b00000000001000,
        ST_TI   = 14'b00000000010000,
        ST_MOVE = 14'b00000000100000,
        ST_DEC  = 14'b00000001000000,
        ST_HX   = 14'b00000010000000,
        ST_M1   = 14'b00000100000000,
        ST_YM   = 14'b00001000000000,
        ST_M2   = 14'b00010000000000,
        ST_M3   = 14'b00100000000000,
        ST_ACC  = 14'b01000000000000,
        ST_EMIT = 14'b10000000000000
    } t_state;

endpackage

`default_nettype wire

@@ design/ellipse_rasterizer.sv @@
// Midpoint ellipse rasterizer: start and step transactions in, four-point sets out.
// Depends on ellras_pkg and on ellipse_rasterizer_defines.svh for its assertions.
//
// Usage: a slave-side transaction with tuser = 0 starts an ellipse from the center and
// radii in tdata; a transaction with tuser = 1 advances it by one midpoint step. Every
// input transaction yields exactly one master-side transaction carrying the four
// symmetric points, valid_res in tuser and tlast on the set whose y offset is zero.
// A step while no ellipse is active yields an all-zero result with valid_res low.
// One shared multiplier with a registered product, run by a small sequencer, does all
// squarings and products; positions and slope terms update in one cycle and the
// decision value in the next. A start squares the radii and forms the initial terms,
// a step moves and then updates the decision value, and an idle step goes straight
// to emit; entering the second region adds five chained multiplications through the
// shared multiplier and accumulator. Emitted results go to the master-side register.
// The block takes a new transaction while a finished result still waits in the output
// register; if the receiver stalls, the next result waits in the sequencer until the
// output register is free. Reset returns the sequencer to idle, clears the output
// valid flag and leaves no ellipse active.
`default_nettype none

module ellipse_rasterizer #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire                                          s_axis_tvalid,
    output logic                                         s_axis_tready,
    // center_x, center_y, radius_x, radius_y, zero fill
    input  wire  [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  wire  [0:0]                                   s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  wire                                          m_axis_tready,
    // pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y, zero fill
    output logic [((8*(COORD_BITS+2)+7)/8)*8-1:0]        m_axis_tdata,
    // valid_res
    output logic [0:0]                                   m_axis_tuser,
    output logic                                         m_axis_tlast
);

    import ellras_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int R      = RADIUS_BITS;
    localparam int OW     = C + 2;
    localparam int OUT_TW = ((8*OW + 7) / 8) * 8;
    localparam int XW     = R + 1;
    localparam int SQW    = 2 * R;
    localparam int SLW    = 3 * R + 4;
    localparam int DW     = 4 * R + 7;
    localparam int MW     = 2 * R + 4;
    localparam int PW     = 2 * MW;
    localparam int SUMW   = ((C > R) ? C : R + 1) + 2;

    t_state                   r_state, n_state;
    logic                     r_active, n_active;
    logic                     r_r2, n_r2;
    logic                     r_null, n_null;
    logic [C-1:0]             r_cx, n_cx;
    logic [C-1:0]             r_cy, n_cy;
    logic [R-1:0]             r_rx, n_rx;
    logic [R-1:0]             r_ry, n_ry;
    logic [SQW-1:0]           r_rx2, n_rx2;
    logic [SQW-1:0]           r_ry2, n_ry2;
    logic [XW-1:0]            r_x, n_x;
    logic [R-1:0]             r_y, n_y;
    logic signed [SLW-1:0]    r_sx, n_sx;
    logic signed [SLW-1:0]    r_sy, n_sy;
    logic [DW-1:0]            r_dec, n_dec;
    logic                     r_mvx, n_mvx;
    logic                     r_mvy, n_mvy;
    logic [PW-1:0]            r_prod;
    logic                     r_m_valid, n_m_valid;
    logic [OUT_TW-1:0]        r_m_tdata, n_m_tdata;
    logic                     r_m_tuser, n_m_tuser;
    logic                     r_m_tlast, n_m_tlast;

    logic [MW-1:0]            w_mul_a, w_mul_b;
    logic [PW-1:0]            w_mul;
    logic [R-1:0]             w_ym;
    logic                     w_accept;
    logic                     w_emit;
    logic                     w_dec_neg, w_dec_pos;
    logic [DW-1:0]            w_ta, w_tb, w_tc;
    logic [SUMW-1:0]          w_cxp, w_cxm, w_cyp, w_cym;
    logic                     w_idle_step;
    logic                     w_emit_r1;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_emit        = (r_state == ST_EMIT) && (!r_m_valid || m_axis_tready);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;
    assign m_axis_tlast  = r_m_tlast;

    assign w_dec_neg = r_dec[DW-1];
    assign w_dec_pos = !r_dec[DW-1] && (|r_dec);
    assign w_ym      = (r_y == '0) ? R'(1) : r_y - R'(1);

    assign w_cxp = SUMW'(r_cx) + SUMW'(r_x);
    assign w_cxm = SUMW'(r_cx) - SUMW'(r_x);
    assign w_cyp = SUMW'(r_cy) + SUMW'(r_y);
    assign w_cym = SUMW'(r_cy) - SUMW'(r_y);

    assign w_ta = r_mvx ? DW'(r_sx) : '0;
    assign w_tb = r_mvy ? DW'(r_sy) : '0;
    assign w_tc = r_r2 ? DW'(r_rx2) : DW'(r_ry2);

    assign w_idle_step = w_accept && (s_axis_tuser[0] == OP_STEP) && !r_active;
    assign w_emit_r1   = (r_state == ST_EMIT) && !r_null && !r_r2;

    always_comb begin
        unique case (r_state)
            ST_SQX: begin
                w_mul_a = MW'(r_rx);
                w_mul_b = MW'(r_rx);
            end
            ST_SQY: begin
                w_mul_a = MW'(r_ry);
                w_mul_b = MW'(r_ry);
            end
            ST_T: begin
                w_mul_a = MW'(r_rx2);
                w_mul_b = MW'(r_ry);
            end
            ST_HX: begin
                w_mul_a = MW'({r_x, 1'b1});
                w_mul_b = MW'({r_x, 1'b1});
            end
            ST_M1: begin
                w_mul_a = MW'(r_ry2);
                w_mul_b = r_prod[MW-1:0];
            end
            ST_YM: begin
                w_mul_a = MW'(w_ym);
                w_mul_b = MW'(w_ym);
            end
            ST_M2: begin
                w_mul_a = MW'(r_rx2);
                w_mul_b = r_prod[MW-1:0];
            end
            ST_M3: begin
                w_mul_a = MW'(r_rx2);
                w_mul_b = MW'(r_ry2);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = w_mul_a * w_mul_b;

    always_comb begin
        n_state   = r_state;
        n_active  = r_active;
        n_r2      = r_r2;
        n_null    = r_null;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_rx2     = r_rx2;
        n_ry2     = r_ry2;
        n_x       = r_x;
        n_y       = r_y;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_dec     = r_dec;
        n_mvx     = r_mvx;
        n_mvy     = r_mvy;
        n_m_valid = (m_axis_tready) ? 1'b0 : r_m_valid;
        n_m_tdata = r_m_tdata;
        n_m_tuser = r_m_tuser;
        n_m_tlast = r_m_tlast;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser[0] == OP_START) begin
                        n_cx    = s_axis_tdata[C-1:0];
                        n_cy    = s_axis_tdata[2*C-1:C];
                        n_rx    = s_axis_tdata[2*C+R-1:2*C];
                        n_ry    = s_axis_tdata[2*C+2*R-1:2*C+R];
                        n_state = ST_SQX;
                    end else if (r_active) begin
                        n_state = ST_MOVE;
                    end else begin
                        n_null  = 1'b1;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SQX: begin
                n_state = ST_SQY;
            end
            ST_SQY: begin
                n_rx2   = r_prod[SQW-1:0];
                n_state = ST_T;
            end
            ST_T: begin
                n_ry2   = r_prod[SQW-1:0];
                n_state = ST_TI;
            end
            ST_TI: begin
                n_x      = '0;
                n_y      = r_ry;
                n_sx     = '0;
                n_sy     = $signed(SLW'(r_prod) << 1);
                n_dec    = (DW'(r_ry2) << 2) - (DW'(r_prod) << 2) + DW'(r_rx2);
                n_active = 1'b1;
                n_null   = 1'b0;
                if (r_prod == '0) begin
                    n_r2    = 1'b1;
                    n_state = ST_HX;
                end else begin
                    n_r2    = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_MOVE: begin
                n_mvx  = !r_r2 || !w_dec_pos;
                n_mvy  = r_r2 || !w_dec_neg;
                n_null = 1'b0;
                if (!r_r2 || !w_dec_pos) begin
                    n_x  = r_x + XW'(1);
                    n_sx = r_sx + $signed(SLW'({r_ry2, 1'b0}));
                end
                if (r_r2 || !w_dec_neg) begin
                    n_y  = r_y - R'(1);
                    n_sy = r_sy - $signed(SLW'({r_rx2, 1'b0}));
                end
                n_state = ST_DEC;
            end
            ST_DEC: begin
                n_dec = r_dec + ((w_ta - w_tb + w_tc) << 2);
                if (!r_r2 && (r_sx >= r_sy)) begin
                    n_r2    = 1'b1;
                    n_state = ST_HX;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_HX: begin
                n_state = ST_M1;
            end
            ST_M1: begin
                n_state = ST_YM;
            end
            ST_YM: begin
                n_dec   = DW'(r_prod);
                n_state = ST_M2;
            end
            ST_M2: begin
                n_state = ST_M3;
            end
            ST_M3: begin
                n_dec   = r_dec + (DW'(r_prod) << 2);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_dec   = r_dec - (DW'(r_prod) << 2);
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_emit) begin
                    n_m_valid = 1'b1;
                    if (r_null) begin
                        n_m_tdata = '0;
                        n_m_tuser = 1'b0;
                        n_m_tlast = 1'b0;
                    end else begin
                        n_m_tdata = OUT_TW'({w_cyp[OW-1:0], w_cxm[OW-1:0],
                                             w_cym[OW-1:0], w_cxp[OW-1:0],
                                             w_cym[OW-1:0], w_cxm[OW-1:0],
                                             w_cyp[OW-1:0], w_cxp[OW-1:0]});
                        n_m_tuser = 1'b1;
                        n_m_tlast = (r_y == '0);
                        n_active  = (r_y != '0);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_active  <= 1'b0;
            r_r2      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_r2      <= n_r2;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_null    <= n_null;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_rx      <= n_rx;
        r_ry      <= n_ry;
        r_rx2     <= n_rx2;
        r_ry2     <= n_ry2;
        r_x       <= n_x;
        r_y       <= n_y;
        r_sx      <= n_sx;
        r_sy      <= n_sy;
        r_dec     <= n_dec;
        r_mvx     <= n_mvx;
        r_mvy     <= n_mvy;
        r_prod    <= w_mul;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
        r_m_tlast <= n_m_tlast;
    end

`include "ellipse_rasterizer_defines.svh"

`ER_ASSERT_NOW(a_last_has_points, r_m_valid && r_m_tlast, r_m_tuser, "last set without points")
`ER_ASSERT_NEXT(a_idle_step_null, w_idle_step, (r_state == ST_EMIT) && r_null, "idle step gave points")
`ER_ASSERT_NEXT(a_region_two_kept, (r_state == ST_MOVE) && r_r2, r_r2, "left region two")
`ER_ASSERT_NOW(a_region_one_slope, w_emit_r1, r_sx < r_sy, "region one emitted past slope -1")

endmodule

`default_nettype wire

@@ tb/ellipse_rasterizer_test.sv @@
// Self-checking testbench for the midpoint ellipse rasterizer.
// Depends on ellras_pkg and the ellipse_rasterizer RTL; a built-in predictor checks
// every four-point set against start and step transactions seen on the input.
`default_nettype none

module ellipse_rasterizer_test;
    import ellras_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;
    localparam int PT_BITS     = COORD_BITS + 2;
    localparam int IN_W        = ((2*COORD_BITS + 2*RADIUS_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((8*PT_BITS + 7) / 8) * 8;
    localparam int NUM_ITEMS   = 1250;
    localparam int WHOLE       = 1000000;
    localparam int IDLE_LIMIT  = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = 20;

    typedef struct {
        bit               valid_res;
        bit [PT_BITS-1:0] coord [8];
        bit               last;
    } t_point_set;

    class ellipse_point_predictor;
        t_point_set             pending_point_sets[$];
        int                     mismatches;
        bit                     active;
        bit                     region_two;
        bit [COORD_BITS-1:0]    ctr_x, ctr_y;
        bit [2*RADIUS_BITS-1:0] rx_sq, ry_sq;
        bit [RADIUS_BITS:0]     px;
        bit [RADIUS_BITS-1:0]   py;
        bit signed [47:0]       dcn;
        bit signed [39:0]       slope_x, slope_y;

        // Four times the region-two decision value at the current position.
        function longint region_two_start();
            longint hx, ym, a, b;
            hx = 2 * longint'(px) + 1;
            ym = longint'(py) - 1;
            a  = longint'(rx_sq);
            b  = longint'(ry_sq);
            return b * hx * hx - 4 * a * b + 4 * a * ym * ym;
        endfunction

        function void maybe_enter_region_two();
            if (!region_two && slope_x >= slope_y) begin
                region_two = 1'b1;
                dcn = 48'(region_two_start());
            end
        endfunction

        function t_point_set current_set();
            t_point_set s;
            longint     x, y, cx, cy;
            x  = longint'(px);
            y  = longint'(py);
            cx = longint'(ctr_x);
            cy = longint'(ctr_y);
            s.valid_res = 1'b1;
            s.coord[0] = PT_BITS'(cx + x);
            s.coord[1] = PT_BITS'(cy + y);
            s.coord[2] = PT_BITS'(cx - x);
            s.coord[3] = PT_BITS'(cy - y);
            s.coord[4] = PT_BITS'(cx + x);
            s.coord[5] = PT_BITS'(cy - y);
            s.coord[6] = PT_BITS'(cx - x);
            s.coord[7] = PT_BITS'(cy + y);
            s.last = (py == 0);
            if (py == 0) begin
                active = 1'b0;
            end
            return s;
        endfunction

        function void accept_command(bit op, bit [COORD_BITS-1:0] cx, bit [COORD_BITS-1:0] cy,
                                     bit [RADIUS_BITS-1:0] rx, bit [RADIUS_BITS-1:0] ry);
            t_point_set s;
            longint     a, b, d, sx, sy;
            if (op == OP_START) begin
                ctr_x   = cx;
                ctr_y   = cy;
                rx_sq   = (2*RADIUS_BITS)'(longint'(rx) * longint'(rx));
                ry_sq   = (2*RADIUS_BITS)'(longint'(ry) * longint'(ry));
                a       = longint'(rx_sq);
                b       = longint'(ry_sq);
                px      = '0;
                py      = ry;
                dcn     = 48'(4 * b - 4 * a * longint'(ry) + a);
                slope_x = '0;
                slope_y = 40'(2 * a * longint'(ry));
                region_two = 1'b0;
                active     = 1'b1;
                maybe_enter_region_two();
                s = current_set();
            end else if (!active) begin
                s.valid_res = 1'b0;
                s.last      = 1'b0;
                for (int i = 0; i < 8; i++) begin
                    s.coord[i] = '0;
                end
            end else begin
                a  = longint'(rx_sq);
                b  = longint'(ry_sq);
                d  = longint'(dcn);
                sx = longint'(slope_x);
                sy = longint'(slope_y);
                if (!region_two) begin
                    px++;
                    sx += 2 * b;
                    if (d < 0) begin
                        d += 4 * (sx + b);
                    end else begin
                        py--;
                        sy -= 2 * a;
                        d += 4 * (sx - sy + b);
                    end
                    dcn = 48'(d);
                    slope_x = 40'(sx);
                    slope_y = 40'(sy);
                    maybe_enter_region_two();
                end else begin
                    py--;
                    sy -= 2 * a;
                    if (d > 0) begin
                        d += 4 * (a - sy);
                    end else begin
                        px++;
                        sx += 2 * b;
                        d += 4 * (sx - sy + a);
                    end
                    dcn = 48'(d);
                    slope_x = 40'(sx);
                    slope_y = 40'(sy);
                end
                s = current_set();
            end
            pending_point_sets.push_back(s);
        endfunction

        function void note_mismatch(string what, bit [PT_BITS-1:0] exp_v,
                                    bit [PT_BITS-1:0] act_v);
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch on %s: expected 0x%0h, got 0x%0h", what, exp_v, act_v);
            end
        endfunction

        function void check_point_set(bit [OUT_W-1:0] data, bit valid_res, bit last);
            t_point_set e;
            string      field_names [8];
            field_names = '{"pa_x", "pa_y", "pb_x", "pb_y", "pc_x", "pc_y", "pd_x", "pd_y"};
            if (pending_point_sets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected point set: data 0x%0h, valid_res %0b, last %0b",
                             data, valid_res, last);
                end
                return;
            end
            e = pending_point_sets.pop_front();
            if (valid_res != e.valid_res) begin
                note_mismatch("valid_res", PT_BITS'(e.valid_res), PT_BITS'(valid_res));
            end
            for (int i = 0; i < 8; i++) begin
                if (data[i*PT_BITS +: PT_BITS] != e.coord[i]) begin
                    note_mismatch(field_names[i], e.coord[i], data[i*PT_BITS +: PT_BITS]);
                end
            end
            if (last != e.last) begin
                note_mismatch("last", PT_BITS'(e.last), PT_BITS'(last));
            end
        endfunction
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    wire              s_axis_tready;
    // center_x, center_y, radius_x, radius_y, zero fill
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    // op
    logic [0:0]       s_axis_tuser  = '0;
    wire              m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y
    wire  [OUT_W-1:0] m_axis_tdata;
    // valid_res
    wire  [0:0]       m_axis_tuser;
    wire              m_axis_tlast;

    ellipse_point_predictor predictor;
    bit                     gaps_on       = 1'b1;
    bit                     long_hold_req = 1'b0;
    int                     items_sent    = 0;

    ellipse_rasterizer #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic send_item(bit op, bit [COORD_BITS-1:0] cx, bit [COORD_BITS-1:0] cy,
                             bit [RADIUS_BITS-1:0] rx, bit [RADIUS_BITS-1:0] ry);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 2*COORD_BITS - 2*RADIUS_BITS){1'b0}}, ry, rx, cy, cx};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        predictor.accept_command(op, cx, cy, rx, ry);
        items_sent++;
    endtask

    // Steps carry random content in the unused fields.
    task automatic send_step();
        send_item(OP_STEP, COORD_BITS'($urandom_range(0, 4095)),
                  COORD_BITS'($urandom_range(0, 4095)),
                  RADIUS_BITS'($urandom_range(0, 2047)),
                  RADIUS_BITS'($urandom_range(0, 2047)));
    endtask

    task automatic draw_ellipse(bit [COORD_BITS-1:0] cx, bit [COORD_BITS-1:0] cy,
                                bit [RADIUS_BITS-1:0] rx, bit [RADIUS_BITS-1:0] ry,
                                int max_steps);
        int steps;
        steps = 0;
        send_item(OP_START, cx, cy, rx, ry);
        while (predictor.active && steps < max_steps) begin
            send_step();
            steps++;
        end
    endtask

    task automatic wait_all_sets();
        s_axis_tvalid <= 1'b0;
        while (predictor.pending_point_sets.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                predictor.check_point_set(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int pick;
        int rx, ry, cut;
        bit hold_done, pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        predictor  = new;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: idle steps, extreme centers and radii, abandoned ellipses,
        // zero radii and an ellipse that reaches y = 0 while still in region one.
        send_step();
        draw_ellipse(12'd0, 12'd0, 11'd2047, 11'd2047, 2);
        draw_ellipse(12'd4095, 12'd4095, 11'd1, 11'd1, WHOLE);
        draw_ellipse(12'd2048, 12'd100, 11'd5, 11'd0, WHOLE);
        send_step();
        draw_ellipse(12'd10, 12'd4000, 11'd0, 11'd3, WHOLE);
        draw_ellipse(12'd300, 12'd300, 11'd8, 11'd1, WHOLE);
        draw_ellipse(12'd1000, 12'd20, 11'd2047, 11'd1, 2);
        draw_ellipse(12'd20, 12'd1000, 11'd1, 11'd2047, 2);

        while (items_sent < NUM_ITEMS) begin
            if (!hold_done && items_sent >= 400) begin
                long_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= 800) begin
                wait_all_sets();
                pause_done = 1'b1;
            end
            if (items_sent >= NUM_ITEMS - 150) begin
                gaps_on = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                if ($urandom_range(0, 99) < 80) begin
                    rx = $urandom_range(0, 24);
                    ry = $urandom_range(0, 24);
                end else begin
                    rx = $urandom_range(1, 90);
                    ry = $urandom_range(1, 90);
                end
                cut = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 10)) : WHOLE;
                draw_ellipse(COORD_BITS'($urandom_range(0, 4095)),
                             COORD_BITS'($urandom_range(0, 4095)),
                             RADIUS_BITS'(rx), RADIUS_BITS'(ry), cut);
            end else if (pick < 93) begin
                send_step();
            end else begin
                draw_ellipse(COORD_BITS'($urandom_range(0, 4095)),
                             COORD_BITS'($urandom_range(0, 4095)),
                             RADIUS_BITS'($urandom_range(0, 2047)),
                             RADIUS_BITS'($urandom_range(0, 2047)),
                             int'($urandom_range(0, 20)));
            end
        end

        wait_all_sets();
        repeat (DRAIN) @(posedge i_clk);
        if (predictor.mismatches == 0 && predictor.pending_point_sets.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
